// ----- rtl/core/e2c_pkg.sv -----
// Shared types and constants for the equirectangular-to-cubemap sampler.
// Holds register limits, stage counts, the arctangent table and the cell payload structs.
// No dependencies.
package e2c_pkg;

  localparam int MAX_FACE     = 4096;
  localparam int MAX_PANO_W   = 8192;
  localparam int MAX_PANO_H   = 4096;
  localparam int DIV_STEPS    = 17;
  localparam int SQRT_STEPS   = 29;
  localparam int CORDIC_ITERS = 28;
  localparam int NUM_STAGES   = 1 + DIV_STEPS + 2 + SQRT_STEPS + 1 + CORDIC_ITERS + 2;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] COLAT_WRAP = 32'hC000_0000;

  localparam logic [1:0] CFG_FACE_SIZE   = 2'd0;
  localparam logic [1:0] CFG_PANO_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_PANO_HEIGHT = 2'd2;

  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;

  localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5
  };

  typedef struct packed {
    logic [29:0] rem_s;
    logic [29:0] rem_t;
    logic [16:0] q_s;
    logic [16:0] q_t;
    logic [2:0]  face;
  } div_t;

  typedef struct packed {
    logic [57:0] rem;
    logic [57:0] res;
    logic [29:0] dx;
    logic [29:0] dy;
    logic [29:0] dz;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        zero;
  } cord_t;

endpackage

// ----- rtl/core/e2c_div_cell.sv -----
// One restoring-division cell: decides one quotient bit of s and of t.
// Depends on e2c_pkg.
module e2c_div_cell
  import e2c_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [12:0] face_size,
  input  div_t        d_i,
  output div_t        d_o
);

  logic [29:0] dvs;
  div_t        d_nxt;

  always_comb begin
    dvs   = 30'(face_size) << SHIFT;
    d_nxt = d_i;
    if (d_i.rem_s >= dvs) begin
      d_nxt.rem_s = d_i.rem_s - dvs;
      d_nxt.q_s   = d_i.q_s | (17'd1 << SHIFT);
    end
    if (d_i.rem_t >= dvs) begin
      d_nxt.rem_t = d_i.rem_t - dvs;
      d_nxt.q_t   = d_i.q_t | (17'd1 << SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule

// ----- rtl/core/e2c_sqrt_cell.sv -----
// One integer square-root cell: settles one result bit, passes the direction along.
// Depends on e2c_pkg.
module e2c_sqrt_cell
  import e2c_pkg::*;
#(
  parameter int K = 0
) (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t d_i,
  output sqrt_t d_o
);

  logic [57:0] bitv;
  logic [57:0] trial;
  sqrt_t       d_nxt;

  always_comb begin
    bitv  = 58'd1 << (2 * K);
    trial = d_i.res + bitv;
    d_nxt = d_i;
    if (d_i.rem >= trial) begin
      d_nxt.rem = d_i.rem - trial;
      d_nxt.res = (d_i.res >> 1) + bitv;
    end else begin
      d_nxt.res = d_i.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule

// ----- rtl/core/e2c_cordic_cell.sv -----
// One vectoring CORDIC cell: one micro-rotation toward the x axis.
// Depends on e2c_pkg.
module e2c_cordic_cell
  import e2c_pkg::*;
#(
  parameter int I = 0
) (
  input  logic  clk,
  input  logic  en,
  input  cord_t d_i,
  output cord_t d_o
);

  logic signed [31:0] xi, yi, xs, ys;
  cord_t              d_nxt;

  always_comb begin
    xi    = d_i.x;
    yi    = d_i.y;
    xs    = xi >>> I;
    ys    = yi >>> I;
    d_nxt = d_i;
    if (!yi[31]) begin
      d_nxt.x = 32'(xi + ys);
      d_nxt.y = 32'(yi - xs);
      d_nxt.z = d_i.z + ATAN_TAB[I];
    end else begin
      d_nxt.x = 32'(xi - ys);
      d_nxt.y = 32'(yi + xs);
      d_nxt.z = d_i.z - ATAN_TAB[I];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_nxt;
    end
  end

endmodule

// ----- rtl/core/equirect_to_cubemap_sampler_top.sv -----
// Equirectangular-to-cubemap sampler: cube pixel in, bilinear panorama address out.
// One item per cycle while the output is not stalled, through an 80-stage chain
// with 17 divider cells, 29 square-root cells and two rows of 28 CORDIC cells.
// The whole chain advances together; an output stall holds every stage.
// Synchronous active-low reset clears valid bits and loads the default registers.
// Depends on e2c_pkg, e2c_div_cell, e2c_sqrt_cell, e2c_cordic_cell.
module equirect_to_cubemap_sampler_top
  import e2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_face,
  input  logic [11:0] in_col,
  input  logic [11:0] in_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] out_src_x0,
  output logic [12:0] out_src_x1,
  output logic [11:0] out_src_y0,
  output logic [11:0] out_src_y1,
  output logic [15:0] out_frac_x,
  output logic [15:0] out_frac_y
);

  logic [12:0] fs_r;
  logic [13:0] w_r;
  logic [12:0] h_r;

  logic [NUM_STAGES-1:0] vld_r;
  logic                  adv;

  div_t  div_q [DIV_STEPS+1];
  sqrt_t sq_q  [SQRT_STEPS+1];
  cord_t lon_q [CORDIC_ITERS+1];
  cord_t col_q [CORDIC_ITERS+1];

  logic signed [17:0] ex_r, ey_r, ez_r;
  logic [45:0] pu_r;
  logic [44:0] pv_r;

  logic [12:0] src_x0_r, src_x1_r;
  logic [11:0] src_y0_r, src_y1_r;
  logic [15:0] frac_x_r, frac_y_r;

  assign adv       = !vld_r[NUM_STAGES-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[NUM_STAGES-1];

  // configuration, stored as effective values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= 13'd512;
      w_r  <= 14'd2048;
      h_r  <= 13'd1024;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FACE_SIZE: begin
          if (cfg_data[12:0] == 13'd0) fs_r <= 13'd1;
          else if (cfg_data[12:0] > 13'(MAX_FACE)) fs_r <= 13'(MAX_FACE);
          else fs_r <= cfg_data[12:0];
        end
        CFG_PANO_WIDTH: begin
          if (cfg_data == 14'd0) w_r <= 14'd1;
          else if (cfg_data > 14'(MAX_PANO_W)) w_r <= 14'(MAX_PANO_W);
          else w_r <= cfg_data;
        end
        CFG_PANO_HEIGHT: begin
          if (cfg_data[12:0] == 13'd0) h_r <= 13'd1;
          else if (cfg_data[12:0] > 13'(MAX_PANO_H)) h_r <= 13'(MAX_PANO_H);
          else h_r <= cfg_data[12:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_valid};
    end
  end

  // input stage: clamp pixel, form dividends
  logic [12:0] fs_m1;
  logic [11:0] c_eff, r_eff;
  div_t        div_nxt;

  always_comb begin
    fs_m1 = fs_r - 13'd1;
    c_eff = ({1'b0, in_col} > fs_m1) ? fs_m1[11:0] : in_col;
    r_eff = ({1'b0, in_row} > fs_m1) ? fs_m1[11:0] : in_row;
    div_nxt.rem_s = {1'b0, c_eff, 1'b1, 16'd0};
    div_nxt.rem_t = {1'b0, r_eff, 1'b1, 16'd0};
    div_nxt.q_s   = '0;
    div_nxt.q_t   = '0;
    div_nxt.face  = in_face;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_q[0] <= div_nxt;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    e2c_div_cell #(.SHIFT(DIV_STEPS - 1 - j)) u_cell (
      .clk       (clk),
      .en        (adv),
      .face_size (fs_r),
      .d_i       (div_q[j]),
      .d_o       (div_q[j+1])
    );
  end

  // face direction in Q1.16
  logic signed [17:0] s_v, t_v, ex_nxt, ey_nxt, ez_nxt;
  localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

  always_comb begin
    s_v = 18'($signed({1'b0, div_q[DIV_STEPS].q_s}) - 19'sd65536);
    t_v = 18'($signed({1'b0, div_q[DIV_STEPS].q_t}) - 19'sd65536);
    case (div_q[DIV_STEPS].face)
      FACE_POS_X: begin ex_nxt = ONE_Q16;  ey_nxt = -t_v;     ez_nxt = -s_v;     end
      FACE_NEG_X: begin ex_nxt = -ONE_Q16; ey_nxt = -t_v;     ez_nxt = s_v;      end
      FACE_POS_Y: begin ex_nxt = s_v;      ey_nxt = ONE_Q16;  ez_nxt = t_v;      end
      FACE_NEG_Y: begin ex_nxt = s_v;      ey_nxt = -ONE_Q16; ez_nxt = -t_v;     end
      FACE_POS_Z: begin ex_nxt = s_v;      ey_nxt = -t_v;     ez_nxt = ONE_Q16;  end
      default:    begin ex_nxt = -s_v;     ey_nxt = -t_v;     ez_nxt = -ONE_Q16; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex_r <= ex_nxt;
      ey_r <= ey_nxt;
      ez_r <= ez_nxt;
    end
  end

  // radial sum of squares, prescaled direction
  logic signed [35:0] sqx, sqz;
  logic [33:0]        sqsum;
  sqrt_t              sq_nxt;

  always_comb begin
    sqx   = ex_r * ex_r;
    sqz   = ez_r * ez_r;
    sqsum = 34'(sqx) + 34'(sqz);
    sq_nxt.rem = {sqsum, 24'd0};
    sq_nxt.res = '0;
    sq_nxt.dx  = 30'({{12{ex_r[17]}}, ex_r} <<< 12);
    sq_nxt.dy  = 30'({{12{ey_r[17]}}, ey_r} <<< 12);
    sq_nxt.dz  = 30'({{12{ez_r[17]}}, ez_r} <<< 12);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_q[0] <= sq_nxt;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    e2c_sqrt_cell #(.K(SQRT_STEPS - 1 - k)) u_cell (
      .clk (clk),
      .en  (adv),
      .d_i (sq_q[k]),
      .d_o (sq_q[k+1])
    );
  end

  // CORDIC entry: half-turn pre-rotation and zero-vector flag
  logic signed [31:0] lx, ly, cx, cy;
  cord_t              lon_nxt, col_nxt;

  always_comb begin
    lx = 32'($signed(sq_q[SQRT_STEPS].dx));
    ly = 32'($signed(sq_q[SQRT_STEPS].dz));
    cx = 32'($signed(sq_q[SQRT_STEPS].dy));
    cy = {3'd0, sq_q[SQRT_STEPS].res[28:0]};
    lon_nxt.zero = (lx == 32'sd0) && (ly == 32'sd0);
    col_nxt.zero = (cx == 32'sd0) && (cy == 32'sd0);
    if (lx[31]) begin
      lon_nxt.x = 32'(-lx);
      lon_nxt.y = 32'(-ly);
      lon_nxt.z = HALF_TURN;
    end else begin
      lon_nxt.x = lx;
      lon_nxt.y = ly;
      lon_nxt.z = '0;
    end
    if (cx[31]) begin
      col_nxt.x = 32'(-cx);
      col_nxt.y = 32'(-cy);
      col_nxt.z = HALF_TURN;
    end else begin
      col_nxt.x = cx;
      col_nxt.y = cy;
      col_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lon_q[0] <= lon_nxt;
      col_q[0] <= col_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
    e2c_cordic_cell #(.I(i)) u_lon (
      .clk (clk),
      .en  (adv),
      .d_i (lon_q[i]),
      .d_o (lon_q[i+1])
    );
    e2c_cordic_cell #(.I(i)) u_col (
      .clk (clk),
      .en  (adv),
      .d_i (col_q[i]),
      .d_o (col_q[i+1])
    );
  end

  // angles to panorama scale
  logic [31:0] lon_a, colat_a, colat_c, ubin, vbin;

  always_comb begin
    lon_a   = lon_q[CORDIC_ITERS].zero ? 32'd0 : lon_q[CORDIC_ITERS].z;
    colat_a = col_q[CORDIC_ITERS].zero ? 32'd0 : col_q[CORDIC_ITERS].z;
    priority if (colat_a >= COLAT_WRAP) colat_c = 32'd0;
    else if (colat_a > HALF_TURN)       colat_c = HALF_TURN;
    else                                colat_c = colat_a;
    ubin = lon_a + HALF_TURN;
    vbin = HALF_TURN - colat_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pu_r <= 46'(ubin) * 46'(w_r);
      pv_r <= 45'(vbin) * 45'(h_r);
    end
  end

  // wrap columns, clamp rows
  logic [30:0] xp;
  logic [28:0] yp;
  logic [14:0] x0p;
  logic [12:0] x0, x1, y0p, hm1, sy0, sy1;

  always_comb begin
    xp  = 31'(pu_r[45:16]) + {1'b0, w_r, 16'd0} - 31'd32768;
    yp  = 29'(pv_r[44:15]) + 29'd32768;
    x0p = xp[30:16];
    x0  = (x0p >= {1'b0, w_r}) ? 13'(x0p - {1'b0, w_r}) : x0p[12:0];
    x1  = ({1'b0, x0} == w_r - 14'd1) ? 13'd0 : x0 + 13'd1;
    y0p = yp[28:16];
    hm1 = h_r - 13'd1;
    sy0 = (y0p == 13'd0) ? 13'd0 : y0p - 13'd1;
    if (sy0 > hm1) sy0 = hm1;
    sy1 = (y0p > hm1) ? hm1 : y0p;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      src_x0_r <= x0;
      src_x1_r <= x1;
      src_y0_r <= sy0[11:0];
      src_y1_r <= sy1[11:0];
      frac_x_r <= xp[15:0];
      frac_y_r <= yp[15:0];
    end
  end

  assign out_src_x0 = src_x0_r;
  assign out_src_x1 = src_x1_r;
  assign out_src_y0 = src_y0_r;
  assign out_src_y1 = src_y1_r;
  assign out_frac_x = frac_x_r;
  assign out_frac_y = frac_y_r;

  a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_src_x0} < w_r && {1'b0, out_src_x1} < w_r))
    else $error("source column outside panorama");

  a_y_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_src_y1 >= out_src_y0 && {1'b0, out_src_y1} < h_r))
    else $error("source rows out of order or range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(vld_r)))
    else $error("chain moved during output stall");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted item not captured");

endmodule

// ----- bench/e2c_checker.sv -----
// Checker for the equirectangular-to-cubemap sampler: tracks register writes,
// predicts each sample address and compares it with the block's results.
// Depends on e2c_pkg.
module e2c_checker
  import e2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_face,
  input  logic [11:0] in_col,
  input  logic [11:0] in_row,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [12:0] out_src_x0,
  input  logic [12:0] out_src_x1,
  input  logic [11:0] out_src_y0,
  input  logic [11:0] out_src_y1,
  input  logic [15:0] out_frac_x,
  input  logic [15:0] out_frac_y,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [12:0] src_x0;
    logic [12:0] src_x1;
    logic [11:0] src_y0;
    logic [11:0] src_y1;
    logic [15:0] frac_x;
    logic [15:0] frac_y;
  } sample_addr_t;

  logic [12:0] face_size_q;
  logic [13:0] pano_width_q;
  logic [12:0] pano_height_q;
  sample_addr_t addr_q[$];

  function automatic longint unsigned clamp_reg(longint unsigned v, longint unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] vector_angle(longint x, longint y);
    logic [31:0] z;
    longint xs, ys;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TAB[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic sample_addr_t predict_addr(logic [2:0] face, logic [11:0] col,
                                                logic [11:0] row);
    longint unsigned fs, w, h, c, r, rad, vbin, xp, yp, x0p, y0p, sy0, sy1;
    longint s, t, dx, dy, dz;
    logic [31:0] ubin, colat;
    sample_addr_t a;
    fs = clamp_reg(face_size_q, MAX_FACE);
    w = clamp_reg(pano_width_q, MAX_PANO_W);
    h = clamp_reg(pano_height_q, MAX_PANO_H);
    c = col;
    r = row;
    if (c > fs - 1) c = fs - 1;
    if (r > fs - 1) r = fs - 1;
    s = longint'(((2 * c + 1) << 16) / fs) - 65536;
    t = longint'(((2 * r + 1) << 16) / fs) - 65536;
    case (face)
      FACE_POS_X: begin dx = 65536;  dy = -t;     dz = -s;     end
      FACE_NEG_X: begin dx = -65536; dy = -t;     dz = s;      end
      FACE_POS_Y: begin dx = s;      dy = 65536;  dz = t;      end
      FACE_NEG_Y: begin dx = s;      dy = -65536; dz = -t;     end
      FACE_POS_Z: begin dx = s;      dy = -t;     dz = 65536;  end
      default:    begin dx = -s;     dy = -t;     dz = -65536; end
    endcase
    dx = dx * 4096;
    dy = dy * 4096;
    dz = dz * 4096;
    ubin = vector_angle(dx, dz) + HALF_TURN;
    rad = int_sqrt(longint'(dx * dx + dz * dz));
    colat = vector_angle(dy, longint'(rad));
    if (colat >= COLAT_WRAP) colat = '0;
    else if (colat > HALF_TURN) colat = HALF_TURN;
    vbin = 64'(HALF_TURN) - 64'(colat);
    xp = ((64'(ubin) * w) >> 16) + (w << 16) - 64'd32768;
    x0p = xp >> 16;
    yp = ((vbin * h) >> 15) + 64'd65536 - 64'd32768;
    y0p = yp >> 16;
    sy0 = (y0p == 0) ? 0 : y0p - 1;
    if (sy0 > h - 1) sy0 = h - 1;
    sy1 = (y0p > h - 1) ? h - 1 : y0p;
    a.src_x0 = 13'(x0p % w);
    a.src_x1 = 13'((x0p + 1) % w);
    a.src_y0 = 12'(sy0);
    a.src_y1 = 12'(sy1);
    a.frac_x = xp[15:0];
    a.frac_y = yp[15:0];
    return a;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    sample_addr_t e;
    if (!rst_n) begin
      face_size_q   = 13'd512;
      pano_width_q  = 14'd2048;
      pano_height_q = 13'd1024;
      addr_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (addr_q.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          e = addr_q.pop_front();
          if (out_src_x0 !== e.src_x0) begin
            $error("src_x0 expected %0d actual %0d", e.src_x0, out_src_x0); errors++;
          end
          if (out_src_x1 !== e.src_x1) begin
            $error("src_x1 expected %0d actual %0d", e.src_x1, out_src_x1); errors++;
          end
          if (out_src_y0 !== e.src_y0) begin
            $error("src_y0 expected %0d actual %0d", e.src_y0, out_src_y0); errors++;
          end
          if (out_src_y1 !== e.src_y1) begin
            $error("src_y1 expected %0d actual %0d", e.src_y1, out_src_y1); errors++;
          end
          if (out_frac_x !== e.frac_x) begin
            $error("frac_x expected %0d actual %0d", e.frac_x, out_frac_x); errors++;
          end
          if (out_frac_y !== e.frac_y) begin
            $error("frac_y expected %0d actual %0d", e.frac_y, out_frac_y); errors++;
          end
        end
      end
      if (in_valid && !in_stall) addr_q.push_back(predict_addr(in_face, in_col, in_row));
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FACE_SIZE:   face_size_q   = cfg_data[12:0];
          CFG_PANO_WIDTH:  pano_width_q  = cfg_data;
          CFG_PANO_HEIGHT: pano_height_q = cfg_data[12:0];
          default: ;
        endcase
      end
    end
    pending = addr_q.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the sampler testbench: clock, reset, register writes, item stimulus,
// output stall pattern and the final verdict.
// Depends on e2c_pkg, equirect_to_cubemap_sampler_top and e2c_checker.
module testbench;
  import e2c_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_wr_en = 0;
  logic [1:0]  cfg_index = '0;
  logic [13:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  in_face = '0;
  logic [11:0] in_col = '0;
  logic [11:0] in_row = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [12:0] out_src_x0, out_src_x1;
  logic [11:0] out_src_y0, out_src_y1;
  logic [15:0] out_frac_x, out_frac_y;
  int          errors, pending;
  int          idle_pct = 33;
  bit          hold_req = 0;
  int          cur_fs = 512;

  always #10 clk = ~clk;

  equirect_to_cubemap_sampler_top u_top (.*);

  e2c_checker u_checker (.*);

  initial begin
    #20_000_000;
    $display("equirect_to_cubemap_sampler_top verification failed");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall = 1;
        repeat (400) @(negedge clk);
      end
      out_stall = ($urandom_range(99) < idle_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [13:0] val);
    @(negedge clk);
    cfg_wr_en = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_geometry(int fs, int w, int h);
    drain();
    write_reg(CFG_FACE_SIZE, 14'(fs));
    write_reg(CFG_PANO_WIDTH, 14'(w));
    write_reg(CFG_PANO_HEIGHT, 14'(h));
    cur_fs = (fs == 0) ? 1 : (fs > MAX_FACE ? MAX_FACE : fs);
  endtask

  task automatic send_item(logic [2:0] face, logic [11:0] col, logic [11:0] row);
    if ($urandom_range(99) < idle_pct) begin
      in_valid = 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1;
    in_face = face;
    in_col = col;
    in_row = row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic random_items(int n);
    logic [11:0] c, r;
    repeat (n) begin
      if ($urandom_range(99) < 15) begin
        c = 12'($urandom);
        r = 12'($urandom);
      end else begin
        c = 12'($urandom_range(cur_fs - 1));
        r = 12'($urandom_range(cur_fs - 1));
      end
      send_item(3'($urandom), c, r);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    for (int f = 0; f < 8; f++) send_item(3'(f), 12'd0, 12'd0);
    for (int f = 0; f < 6; f++) send_item(3'(f), 12'd511, 12'd511);
    send_item(FACE_POS_Y, 12'd255, 12'd256);
    send_item(FACE_NEG_Y, 12'd256, 12'd255);
    send_item(FACE_POS_X, 12'd4095, 12'd0);
    send_item(FACE_NEG_X, 12'd0, 12'd4095);
    send_item(FACE_POS_Z, 12'd2730, 12'd1365);
    set_geometry(1, 1, 1);
    send_item(FACE_POS_Y, 12'd0, 12'd0);
    send_item(FACE_NEG_Y, 12'd4095, 12'd4095);
    set_geometry(0, 0, 0);
    send_item(FACE_NEG_X, 12'd7, 12'd9);
    drain();
    write_reg(CFG_UNUSED, 14'h3FFF);
    send_item(FACE_POS_Z, 12'd0, 12'd0);

    set_geometry(2, 3, 2);
    random_items(150);
    set_geometry(8191, 16383, 8191);
    random_items(150);
    set_geometry(4096, 8192, 4096);
    random_items(200);
    set_geometry(512, 2048, 1024);
    idle_pct = 0;
    random_items(300);
    idle_pct = 33;
    hold_req = 1;
    random_items(300);
    drain();
    set_geometry($urandom_range(1, 64), $urandom_range(1, 200), $urandom_range(1, 100));
    random_items(300);
    set_geometry($urandom_range(1, 8191), $urandom_range(1, 16383),
                 $urandom_range(1, 8191));
    random_items(300);

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("equirect_to_cubemap_sampler_top verification clean");
    else
      $display("equirect_to_cubemap_sampler_top verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/e2c_pkg.sv
rtl/core/e2c_div_cell.sv
rtl/core/e2c_sqrt_cell.sv
rtl/core/e2c_cordic_cell.sv
rtl/core/equirect_to_cubemap_sampler_top.sv
bench/e2c_checker.sv
bench/testbench.sv
